// File: rtl/qet_pkg.sv
// ----------------------------------------------------------------------------
// qet_pkg
// Types, constants and helpers shared by the quoted escape tokenizer.
// ----------------------------------------------------------------------------
package qet_pkg;

	localparam int CH_W    = 21;
	localparam int CNT_W   = 16;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [CH_W-1:0] C_QUOTE = CH_W'(34);
	localparam logic [CH_W-1:0] C_BSL   = CH_W'(92);
	localparam logic [CH_W-1:0] C_SPACE = CH_W'(32);
	localparam logic [CH_W-1:0] C_T     = CH_W'(116);
	localparam logic [CH_W-1:0] C_N     = CH_W'(110);
	localparam logic [CH_W-1:0] C_R     = CH_W'(114);
	localparam logic [CH_W-1:0] C_V     = CH_W'(118);
	localparam logic [CH_W-1:0] C_TAB   = CH_W'(9);
	localparam logic [CH_W-1:0] C_LF    = CH_W'(10);
	localparam logic [CH_W-1:0] C_VT    = CH_W'(11);
	localparam logic [CH_W-1:0] C_CR    = CH_W'(13);

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_TEND = 2'd1,
		KIND_LEND = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		MODE_BETWEEN = 3'b001,
		MODE_PLAIN   = 3'b010,
		MODE_QUOTED  = 3'b100
	} mode_t;

	typedef enum logic [1:0] {
		OP_CHAR      = 2'd0,
		OP_TEND      = 2'd1,
		OP_LEND      = 2'd2,
		OP_TEND_LEND = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [CH_W-1:0]  ch;
		logic [CNT_W-1:0] count;
	} cmd_t;

	function automatic logic is_space(input logic [CH_W-1:0] c);
		return (c == C_SPACE) || (c >= C_TAB && c <= C_CR);
	endfunction

	function automatic logic [CH_W-1:0] translate(input logic [CH_W-1:0] c);
		logic [CH_W-1:0] r;
		r = c;
		if (c == C_T) r = C_TAB;
		else if (c == C_N) r = C_LF;
		else if (c == C_R) r = C_CR;
		else if (c == C_V) r = C_VT;
		return r;
	endfunction

endpackage

// File: rtl/qet_intf.sv
// ----------------------------------------------------------------------------
// qet_intf
// Character input and result output channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qet_in_if import qet_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;
	logic            line_end;

	modport source (output valid, ch, line_end, input ready);
	modport sink   (input valid, ch, line_end, output ready);
endinterface

interface qet_out_if import qet_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       out_kind;
	logic [CH_W-1:0]  out_char;
	logic [CNT_W-1:0] token_count;
	logic             last;

	modport source (output valid, out_kind, out_char, token_count, last, input ready);
	modport sink   (input valid, out_kind, out_char, token_count, last, output ready);
endinterface

// File: rtl/quoted_escape_tokenizer.sv
// ----------------------------------------------------------------------------
// quoted_escape_tokenizer
// Splits a character stream into shell-style tokens with quotes and escapes.
//
//   channel  dir  words                         handshake
//   in_ch    in   ch, line_end                  valid/ready
//   out_tok  out  out_kind, out_char,           valid/ready
//                 token_count, last
//
// One character accepted per cycle; each word goes through the queue and
// the output register. A line end inside a token gives two words and holds
// the back end for the second word; the four-entry queue absorbs that.
// Reset clears scan state, count, queue pointers and output valid; no clearing
// pass.
// Input stalls only when the queue is full.
// ----------------------------------------------------------------------------
module quoted_escape_tokenizer import qet_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	qet_in_if.sink     in_ch,
	qet_out_if.source  out_tok
);

	localparam int CW = (COUNT_BITS > CNT_W) ? CNT_W : COUNT_BITS;

	logic              push, pop, q_full, q_empty;
	cmd_t              push_data, head;
	logic [QCNT_W-1:0] q_level;

	qet_front #(.CW(CW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	qet_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty),
		.level     (q_level)
	);

	qet_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.out_tok (out_tok)
	);

	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= QCNT_W'(QDEPTH))
		else $error("queue level out of range");

	a_split: assert property (@(posedge clk) disable iff (!arst_n)
		out_tok.valid && out_tok.ready && out_tok.out_kind == KIND_TEND && !out_tok.last
		|=> out_tok.valid && out_tok.out_kind == KIND_LEND && out_tok.last)
		else $error("split token end not followed by line end");

	a_lend_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_tok.valid && out_tok.out_kind == KIND_LEND |-> out_tok.last)
		else $error("line end word without last");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !in_ch.ready)
		else $error("input taken with full queue");

endmodule

// File: rtl/qet_front.sv
// ----------------------------------------------------------------------------
// qet_front
// Accepts characters, tracks scan mode and count, pushes result commands.
// ----------------------------------------------------------------------------
module qet_front import qet_pkg::*; #(
	parameter int CW = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	qet_in_if.sink     in_ch,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_data
);

	localparam logic [CW-1:0] LIMIT = '1;

	mode_t          mode_q, mode_d;
	logic           esc_q, esc_d;
	logic [CW-1:0]  cnt_q, cnt_d, cnt_inc;
	logic           accept, lend, emit;
	op_t            op;
	logic [CH_W-1:0] och;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && !q_full;
	assign lend        = in_ch.line_end || (in_ch.ch == '0);
	assign cnt_inc     = (cnt_q == LIMIT) ? cnt_q : cnt_q + CW'(1);

	always_comb begin
		mode_d = mode_q;
		esc_d  = esc_q;
		cnt_d  = cnt_q;
		emit   = 1'b0;
		op     = OP_CHAR;
		och    = in_ch.ch;
		if (lend) begin
			emit   = 1'b1;
			mode_d = MODE_BETWEEN;
			esc_d  = 1'b0;
			cnt_d  = '0;
			if (mode_q != MODE_BETWEEN) op = OP_TEND_LEND;
			else                        op = OP_LEND;
		end else begin
			case (mode_q)
				MODE_PLAIN: begin
					if (is_space(in_ch.ch)) begin
						emit   = 1'b1;
						op     = OP_TEND;
						mode_d = MODE_BETWEEN;
						esc_d  = 1'b0;
						cnt_d  = cnt_inc;
					end else if (esc_q) begin
						emit  = 1'b1;
						esc_d = 1'b0;
						och   = translate(in_ch.ch);
					end else if (in_ch.ch == C_BSL) begin
						esc_d = 1'b1;
					end else begin
						emit = 1'b1;
					end
				end
				MODE_QUOTED: begin
					if (esc_q) begin
						emit  = 1'b1;
						esc_d = 1'b0;
						och   = translate(in_ch.ch);
					end else if (in_ch.ch == C_BSL) begin
						esc_d = 1'b1;
					end else if (in_ch.ch == C_QUOTE) begin
						emit   = 1'b1;
						op     = OP_TEND;
						mode_d = MODE_BETWEEN;
						cnt_d  = cnt_inc;
					end else begin
						emit = 1'b1;
					end
				end
				default: begin
					esc_d = 1'b0;
					if (is_space(in_ch.ch)) begin
						mode_d = MODE_BETWEEN;
					end else if (in_ch.ch == C_QUOTE) begin
						mode_d = MODE_QUOTED;
					end else if (in_ch.ch == C_BSL) begin
						mode_d = MODE_PLAIN;
						esc_d  = 1'b1;
					end else begin
						mode_d = MODE_PLAIN;
						emit   = 1'b1;
					end
				end
			endcase
		end
	end

	assign push            = accept && emit;
	assign push_data.op    = op;
	assign push_data.ch    = (op == OP_CHAR) ? och : '0;
	assign push_data.count = (op == OP_LEND) ? CNT_W'(cnt_q) :
	                         (op == OP_TEND_LEND) ? CNT_W'(cnt_inc) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BETWEEN;
			esc_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			esc_q  <= esc_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

// File: rtl/qet_queue.sv
// ----------------------------------------------------------------------------
// qet_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module qet_queue import qet_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cmd_t              push_data,
	input  logic              pop,
	output cmd_t              head,
	output logic              full,
	output logic              empty,
	output logic [QCNT_W-1:0] level
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign level   = cnt_q;
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + QPTR_W'(1);
			if (do_pop)  rd_q <= rd_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
		end
	end

endmodule

// File: rtl/qet_back.sv
// ----------------------------------------------------------------------------
// qet_back
// Expands queued commands into output words held in an output register.
// ----------------------------------------------------------------------------
module qet_back import qet_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cmd_t       head,
	output logic       pop,
	qet_out_if.source  out_tok
);

	logic             valid_q, phase_q, load, split;
	kind_t            kind_q;
	logic [CH_W-1:0]  char_q;
	logic [CNT_W-1:0] count_q;
	logic             last_q;

	assign load  = !valid_q || out_tok.ready;
	assign split = (head.op == OP_TEND_LEND) && !phase_q;
	assign pop   = load && !q_empty && !split;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= !q_empty;
			if (!q_empty) phase_q <= split;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			char_q  <= head.ch;
			count_q <= split ? '0 : head.count;
			last_q  <= !split;
			case (head.op)
				OP_CHAR:      kind_q <= KIND_CHAR;
				OP_TEND:      kind_q <= KIND_TEND;
				OP_LEND:      kind_q <= KIND_LEND;
				OP_TEND_LEND: kind_q <= split ? KIND_TEND : KIND_LEND;
				default:      kind_q <= KIND_LEND;
			endcase
		end
	end

	assign out_tok.valid       = valid_q;
	assign out_tok.out_kind    = kind_q;
	assign out_tok.out_char    = char_q;
	assign out_tok.token_count = count_q;
	assign out_tok.last        = last_q;

endmodule

// File: tb/sv/quoted_escape_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_escape_tokenizer_tb
// Checks the tokenizer word by word against an in-bench model of its scan
// state. The directed lines cover quotes, escapes, blanks and line ends.
// Random lines follow, with noise mixed in. One long line of empty quoted
// tokens checks the token count. The sender and the receiver idle at random.
// ----------------------------------------------------------------------------
module quoted_escape_tokenizer_tb;
	import qet_pkg::*;

	localparam int TOK_COUNT_BITS = 16;
	localparam logic [CNT_W-1:0] CNT_LIMIT = (TOK_COUNT_BITS >= CNT_W) ?
		{CNT_W{1'b1}} : CNT_W'((1 << TOK_COUNT_BITS) - 1);
	localparam logic [CH_W-1:0] CH_A = CH_W'(97);
	localparam logic [CH_W-1:0] CH_Q = CH_W'(113);
	localparam int RANDOM_PER_PHASE = 420;
	localparam int LONG_LINE_TOKENS = 40;
	localparam int HOLD_LEN = 100;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;

	typedef enum int {
		PH_SLOW_SINK,
		PH_SLOW_SOURCE,
		PH_FULL_RATE
	} phase_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            line_end;
	} char_item_t;

	typedef struct packed {
		kind_t            kind;
		logic [CH_W-1:0]  ch;
		logic [CNT_W-1:0] count;
		logic             last;
	} word_t;

	logic clk = 1'b0;
	logic arst_n;

	qet_in_if  in_ch();
	qet_out_if out_tok();

	quoted_escape_tokenizer #(.COUNT_BITS(TOK_COUNT_BITS)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_tok (out_tok)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	char_item_t       line_chars[$];
	word_t            expected_words[$];
	char_item_t       next_item;
	word_t            head_w;
	int               queued_cnt = 0;
	int               mismatch_cnt = 0;
	int               hold_cycles;
	phase_t           phase = PH_SLOW_SINK;
	int               src_idle_pct = 26;
	int               sink_idle_pct = 82;

	// model state
	mode_t            scan = MODE_BETWEEN;
	logic             esc_pend = 1'b0;
	logic [CNT_W-1:0] tok_count = '0;

	function automatic logic is_blank(input logic [CH_W-1:0] c);
		return c == C_SPACE || (c >= C_TAB && c <= C_CR);
	endfunction

	function automatic logic [CH_W-1:0] unescape(input logic [CH_W-1:0] c);
		case (c)
			C_T:     return C_TAB;
			C_N:     return C_LF;
			C_R:     return C_CR;
			C_V:     return C_VT;
			default: return c;
		endcase
	endfunction

	function automatic void close_token();
		if (tok_count < CNT_LIMIT)
			tok_count = tok_count + 1'b1;
		scan = MODE_BETWEEN;
		esc_pend = 1'b0;
	endfunction

	function automatic void tokenize(input logic [CH_W-1:0] c, input logic le);
		word_t w[2];
		int    n;
		n = 0;
		if (le || c == '0) begin
			if (scan != MODE_BETWEEN) begin
				close_token();
				w[n] = '{KIND_TEND, '0, '0, 1'b0};
				n++;
			end
			w[n] = '{KIND_LEND, '0, tok_count, 1'b0};
			n++;
			scan = MODE_BETWEEN;
			esc_pend = 1'b0;
			tok_count = '0;
		end else begin
			case (scan)
				MODE_PLAIN: begin
					if (is_blank(c)) begin
						close_token();
						w[n] = '{KIND_TEND, '0, '0, 1'b0};
						n++;
					end else if (esc_pend) begin
						esc_pend = 1'b0;
						w[n] = '{KIND_CHAR, unescape(c), '0, 1'b0};
						n++;
					end else if (c == C_BSL) begin
						esc_pend = 1'b1;
					end else begin
						w[n] = '{KIND_CHAR, c, '0, 1'b0};
						n++;
					end
				end
				MODE_QUOTED: begin
					if (esc_pend) begin
						esc_pend = 1'b0;
						w[n] = '{KIND_CHAR, unescape(c), '0, 1'b0};
						n++;
					end else if (c == C_BSL) begin
						esc_pend = 1'b1;
					end else if (c == C_QUOTE) begin
						close_token();
						w[n] = '{KIND_TEND, '0, '0, 1'b0};
						n++;
					end else begin
						w[n] = '{KIND_CHAR, c, '0, 1'b0};
						n++;
					end
				end
				default: begin
					esc_pend = 1'b0;
					if (is_blank(c)) begin
					end else if (c == C_QUOTE) begin
						scan = MODE_QUOTED;
					end else if (c == C_BSL) begin
						scan = MODE_PLAIN;
						esc_pend = 1'b1;
					end else begin
						scan = MODE_PLAIN;
						w[n] = '{KIND_CHAR, c, '0, 1'b0};
						n++;
					end
				end
			endcase
		end
		for (int i = 0; i < n; i++) begin
			w[i].last = (i == n - 1);
			expected_words.push_back(w[i]);
		end
	endfunction

	// stimulus
	function automatic void push_char(input logic [CH_W-1:0] c);
		line_chars.push_back('{c, 1'b0});
		queued_cnt++;
	endfunction

	function automatic void push_line_end();
		line_chars.push_back('{CH_W'($urandom), 1'b1});
		queued_cnt++;
	endfunction

	function automatic logic [CH_W-1:0] pick_blank();
		int r;
		r = $urandom_range(5);
		return (r == 5) ? C_SPACE : CH_W'(9 + r);
	endfunction

	function automatic logic [CH_W-1:0] pick_text();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return CH_W'($urandom_range(33, 126));
		if (r < 75) begin
			case ($urandom_range(3))
				0:       return C_T;
				1:       return C_N;
				2:       return C_R;
				default: return C_V;
			endcase
		end
		if (r < 85)
			return CH_W'($urandom_range(1, 8));
		if (r < 90)
			return CH_W'($urandom_range(14, 31));
		return CH_W'($urandom_range(127, 21'h1FFFFF));
	endfunction

	function automatic void gen_line();
		int ntok;
		int len;
		ntok = $urandom_range(0, 6);
		for (int t = 0; t < ntok; t++) begin
			repeat ($urandom_range((t == 0) ? 0 : 1, 3))
				push_char(pick_blank());
			if ($urandom_range(99) < 60) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(99) < 20)
						push_char(C_BSL);
					push_char(pick_text());
				end
			end else begin
				push_char(C_QUOTE);
				len = $urandom_range(0, 6);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(99) < 15) begin
						push_char(C_BSL);
						push_char(($urandom_range(1) == 0) ? C_QUOTE : pick_text());
					end else begin
						push_char(($urandom_range(3) == 0) ? pick_blank() : pick_text());
					end
				end
				if ($urandom_range(99) >= 90)
					break;
				push_char(C_QUOTE);
			end
		end
		if ($urandom_range(99) < 75)
			push_line_end();
		else
			push_char('0);
	endfunction

	function automatic void gen_noise();
		int r;
		repeat ($urandom_range(1, 12)) begin
			r = $urandom_range(99);
			if (r < 8)
				push_line_end();
			else if (r < 35)
				push_char(CH_W'($urandom));
			else if (r < 55) begin
				case ($urandom_range(2))
					0:       push_char('0);
					1:       push_char(C_QUOTE);
					default: push_char(C_BSL);
				endcase
			end else if (r < 70)
				push_char(pick_blank());
			else
				push_char(pick_text());
		end
	endfunction

	function automatic void gen_random(input int n_items);
		int target;
		target = queued_cnt + n_items;
		while (queued_cnt < target) begin
			if ($urandom_range(99) < 85)
				gen_line();
			else
				gen_noise();
		end
	endfunction

	task automatic wait_drained();
		while (line_chars.size() != 0 || in_ch.valid || expected_words.size() != 0)
			@(negedge clk);
	endtask

	// character driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.ch <= '0;
			in_ch.line_end <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				tokenize(in_ch.ch, in_ch.line_end);
			if (!in_ch.valid || in_ch.ready) begin
				if (line_chars.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					next_item = line_chars.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.ch <= next_item.ch;
					in_ch.line_end <= next_item.line_end;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// word monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_tok.ready <= 1'b0;
			hold_cycles = 0;
		end else begin
			if (out_tok.valid && out_tok.ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word: out_kind %0d, out_char %0h",
						out_tok.out_kind, out_tok.out_char);
					mismatch_cnt++;
				end else begin
					head_w = expected_words.pop_front();
					if (out_tok.out_kind !== head_w.kind) begin
						$error("out_kind: expected %0d, got %0d", head_w.kind,
							out_tok.out_kind);
						mismatch_cnt++;
					end
					if (out_tok.out_char !== head_w.ch) begin
						$error("out_char: expected %0h, got %0h", head_w.ch,
							out_tok.out_char);
						mismatch_cnt++;
					end
					if (out_tok.token_count !== head_w.count) begin
						$error("token_count: expected %0d, got %0d", head_w.count,
							out_tok.token_count);
						mismatch_cnt++;
					end
					if (out_tok.last !== head_w.last) begin
						$error("last: expected %0d, got %0d", head_w.last, out_tok.last);
						mismatch_cnt++;
					end
				end
			end
			// long hold-off at the start of the full-rate phase fills the queue
			if (phase == PH_FULL_RATE && hold_cycles < HOLD_LEN) begin
				hold_cycles++;
				out_tok.ready <= 1'b0;
			end else begin
				out_tok.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_tok.valid && out_tok.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// max code, CR ends token, control char, line end inside a token
		push_char(21'h1FFFFF);
		push_char(C_CR);
		push_char(CH_W'(8));
		push_line_end();
		// quoted token with blank, closing quote then next token, zero ends line
		push_char(C_QUOTE);
		push_char(CH_A);
		push_char(C_SPACE);
		push_char(CH_Q);
		push_char(C_QUOTE);
		push_char(C_QUOTE);
		push_char(CH_A);
		push_char('0);
		// empty quoted token, escapes t and n, escaped blank ends a token
		push_char(C_QUOTE);
		push_char(C_QUOTE);
		push_char(C_BSL);
		push_char(C_T);
		push_char(C_BSL);
		push_char(C_N);
		push_char(C_SPACE);
		push_char(C_BSL);
		push_char(C_SPACE);
		push_line_end();
		// unclosed quote: r, v, escaped quote, trailing backslash
		push_char(C_QUOTE);
		push_char(C_BSL);
		push_char(C_R);
		push_char(C_BSL);
		push_char(C_V);
		push_char(C_BSL);
		push_char(C_QUOTE);
		push_char(C_BSL);
		push_line_end();

		gen_random(RANDOM_PER_PHASE);
		wait_drained();

		phase = PH_SLOW_SOURCE;
		src_idle_pct = 82;
		sink_idle_pct = 26;
		gen_random(RANDOM_PER_PHASE);
		wait_drained();

		phase = PH_FULL_RATE;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		gen_random(RANDOM_PER_PHASE);
		// long line of empty quoted tokens
		repeat (LONG_LINE_TOKENS) begin
			push_char(C_QUOTE);
			push_char(C_QUOTE);
		end
		push_char(CH_A);
		push_line_end();
		gen_random(40);
		wait_drained();

		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_cnt == 0 && expected_words.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
rtl/qet_pkg.sv
rtl/qet_intf.sv
rtl/qet_front.sv
rtl/qet_queue.sv
rtl/qet_back.sv
rtl/quoted_escape_tokenizer.sv
tb/sv/quoted_escape_tokenizer_tb.sv
